@@ rtl/core/gbgc_pkg.sv @@
// Gyro bias and gain calibrator: shared widths, constants, codes and the
// structs passed between the sequencer, the divider and the top level.
// No dependencies.
package gbgc_pkg;

   localparam int ADC_BITS_DEF  = 12;
   localparam int MAX_REV_DEF   = 255;

   localparam int SAMPLE_W      = 12;
   localparam int TS_W          = 32;
   localparam int VALUE_W       = 32;
   localparam int LIMIT_W       = 16;
   localparam int FIRST_W       = 20;
   localparam int CSR_DATA_W    = 20;
   localparam int CSR_INDEX_W   = 1;
   localparam int COUNT_W       = 17;
   localparam int REST_SUM_W    = 29;
   localparam int BIAS_W        = 20;
   localparam int TERM_W        = 21;
   localparam int PROD_W        = 54;
   localparam int INTEG_W       = 64;
   localparam int GSUM_W        = 48;
   localparam int GAIN_W        = 31;
   localparam int DIV_W         = 64;
   localparam int QUOT_W        = 32;
   localparam int REQ_DATA_W    = 56;
   localparam int RSP_DATA_W    = 72;
   localparam int KIND_W        = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd150;
   localparam logic [FIRST_W-1:0] FIRST_RESET = 20'd50000;
   localparam logic [DIV_W-1:0]   GAIN_NUM    = 64'd6039797760000000;
   localparam logic [INTEG_W-1:0] INTEG_MAX   = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic [INTEG_W-1:0] INTEG_MIN   = {1'b1, {(INTEG_W-2){1'b0}}, 1'b1};
   localparam logic [GSUM_W-1:0]  GSUM_MAX    = {GSUM_W{1'b1}};
   localparam logic [GAIN_W-1:0]  GAIN_MAX    = {GAIN_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_REST_LIMIT     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_INTERVAL = 1'b1;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_START  = 2'd1,
      OP_END    = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BIAS = 2'd0,
      KIND_GAIN = 2'd1,
      KIND_MEAN = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_REST = 2'd0,
      PH_IDLE = 2'd1,
      PH_REV  = 2'd2
   } phase_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic              big;
   } div_rsp_type;

   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [VALUE_W-1:0] value_1x;
      logic [VALUE_W-1:0] value_4x;
      logic               valid_1x;
      logic               valid_4x;
   } result_type;

endpackage

@@ rtl/core/gbgc_div.sv @@
// Gyro bias and gain calibrator: shared restoring divider, one quotient bit
// per cycle over a 64-bit dividend. Depends on gbgc_pkg.
module gbgc_div
   import gbgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req_i,
   output div_rsp_type rsp_o
);

   localparam int STEP_W = $clog2(DIV_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              big_ff, big_in;

   logic [DIV_W:0]    rem_sh;
   logic [DIV_W:0]    diff;
   logic              ge;

   assign rem_sh = {rem_ff, num_ff[DIV_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      big_in  = big_ff;
      if (busy_ff) begin
         rem_in  = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         num_in  = {num_ff[DIV_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         big_in  = big_ff | quot_ff[QUOT_W-1];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req_i.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         num_in  = req_i.num;
         den_in  = req_i.den;
         quot_in = '0;
         big_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      big_ff  <= big_in;
   end

   assign rsp_o.busy = busy_ff;
   assign rsp_o.done = done_ff;
   assign rsp_o.quot = quot_ff;
   assign rsp_o.big  = big_ff | quot_ff[QUOT_W-1];

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

   a_step_parked: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == '0))
      else $error("divider step count not parked at zero when idle");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == LAST_STEP) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after its last step");

endmodule

@@ rtl/core/gbgc_seq.sv @@
// Gyro bias and gain calibrator: request sequencer with calibration state,
// shared multiply-accumulate and divider scheduling. Depends on gbgc_pkg.
module gbgc_seq
   import gbgc_pkg::*;
#(
   parameter int ADC_BITS        = ADC_BITS_DEF,
   parameter int MAX_REVOLUTIONS = MAX_REV_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]             req_tuser,
   output div_req_type            div_req_o,
   input  div_rsp_type            div_rsp_i,
   input  logic                   slot_free_i,
   output result_type             result_o
);

   localparam int SAMPLE_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
   localparam int GCOUNT_W = $clog2(MAX_REVOLUTIONS + 1);
   localparam logic [GCOUNT_W-1:0] MAX_COUNT = GCOUNT_W'(MAX_REVOLUTIONS);
   localparam logic [COUNT_W-1:0] COUNT_CEIL = COUNT_W'(1 << LIMIT_W);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DISPATCH = 7'b0000010,
      S_MUL      = 7'b0000100,
      S_ACC      = 7'b0001000,
      S_DIV_GO   = 7'b0010000,
      S_DIV_WAIT = 7'b0100000,
      S_EMIT     = 7'b1000000
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [FIRST_W-1:0]   first_ff, first_in;
   logic [COUNT_W-1:0]   rest_count_ff, rest_count_in;
   logic [REST_SUM_W-1:0] rest_sum_ff [2];
   logic [REST_SUM_W-1:0] rest_sum_in [2];
   logic [BIAS_W-1:0]    bias_ff [2];
   logic [BIAS_W-1:0]    bias_in [2];
   logic [TS_W-1:0]      last_time_ff, last_time_in;
   logic                 pending_ff, pending_in;
   logic [INTEG_W-1:0]   integ_ff [2];
   logic [INTEG_W-1:0]   integ_in [2];
   logic [GSUM_W-1:0]    gsum_ff [2];
   logic [GSUM_W-1:0]    gsum_in [2];
   logic [GCOUNT_W-1:0]  gcount_ff [2];
   logic [GCOUNT_W-1:0]  gcount_in [2];
   logic                 ch_ff, ch_in;
   kind_type             kind_ff, kind_in;

   op_type               op_ff, op_in;
   logic [SAMPLE_W-1:0]  samp_ff [2];
   logic [SAMPLE_W-1:0]  samp_in [2];
   logic [TS_W-1:0]      ts_ff, ts_in;
   logic [TS_W-1:0]      dt_ff, dt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [VALUE_W-1:0]   res_val_ff [2];
   logic [VALUE_W-1:0]   res_val_in [2];
   logic                 res_ok_ff [2];
   logic                 res_ok_in [2];

   logic [COUNT_W-1:0]   count_inc;
   logic signed [TERM_W-1:0] term;
   logic [INTEG_W-1:0]   integ_cur;
   logic [INTEG_W-1:0]   mag;
   logic [INTEG_W:0]     sat_sum;
   logic [INTEG_W-1:0]   sat_val;
   logic [GAIN_W-1:0]    gain_q;
   logic [VALUE_W-1:0]   gain_pos;
   logic [GSUM_W:0]      gsum_add;
   logic [DIV_W-1:0]     div_num;
   logic [DIV_W-1:0]     div_den;
   logic                 div_start;

   assign req_tready = (state_ff == S_IDLE);
   assign count_inc  = rest_count_ff + 1'b1;
   assign term       = $signed({1'b0, samp_ff[ch_ff], 8'b0}) - $signed({1'b0, bias_ff[ch_ff]});
   assign integ_cur  = integ_ff[ch_ff];
   assign mag        = integ_cur[INTEG_W-1] ? (~integ_cur + 1'b1) : integ_cur;
   assign sat_sum    = {integ_cur[INTEG_W-1], integ_cur}
                     + {{(INTEG_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign gain_q     = div_rsp_i.big ? GAIN_MAX : div_rsp_i.quot[GAIN_W-1:0];
   assign gain_pos   = {1'b0, gain_q};
   assign gsum_add   = {1'b0, gsum_ff[ch_ff]} + (GSUM_W+1)'(gain_q);

   always_comb begin
      if (sat_sum[INTEG_W:INTEG_W-1] == 2'b01) begin
         sat_val = INTEG_MAX;
      end else if (sat_sum[INTEG_W:INTEG_W-1] == 2'b10 ||
                   sat_sum == {2'b11, {(INTEG_W-1){1'b0}}}) begin
         sat_val = INTEG_MIN;
      end else begin
         sat_val = sat_sum[INTEG_W-1:0];
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_BIAS: begin
            div_num = DIV_W'({rest_sum_ff[ch_ff], 8'b0}) + DIV_W'(rest_count_ff >> 1);
            div_den = DIV_W'(rest_count_ff);
         end
         KIND_GAIN: begin
            div_num = GAIN_NUM + (mag >> 1);
            div_den = mag;
         end
         default: begin
            div_num = DIV_W'(gsum_ff[ch_ff]) + DIV_W'(gcount_ff[ch_ff] >> 1);
            div_den = DIV_W'(gcount_ff[ch_ff]);
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      limit_in      = limit_ff;
      first_in      = first_ff;
      rest_count_in = rest_count_ff;
      rest_sum_in   = rest_sum_ff;
      bias_in       = bias_ff;
      last_time_in  = last_time_ff;
      pending_in    = pending_ff;
      integ_in      = integ_ff;
      gsum_in       = gsum_ff;
      gcount_in     = gcount_ff;
      ch_in         = ch_ff;
      kind_in       = kind_ff;
      op_in         = op_ff;
      samp_in       = samp_ff;
      ts_in         = ts_ff;
      dt_in         = dt_ff;
      prod_in       = prod_ff;
      res_val_in    = res_val_ff;
      res_ok_in     = res_ok_ff;
      div_start     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_REST_LIMIT:     limit_in = csr_wdata[LIMIT_W-1:0];
            CSR_FIRST_INTERVAL: first_in = csr_wdata[FIRST_W-1:0];
            default:            limit_in = limit_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = op_type'(req_tuser);
               samp_in[0] = req_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;
               samp_in[1] = req_tdata[2*SAMPLE_W-1:SAMPLE_W] & SAMPLE_MASK;
               ts_in      = req_tdata[2*SAMPLE_W +: TS_W];
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            ch_in    = 1'b0;
            case (op_ff)
               OP_SAMPLE: begin
                  if (phase_ff == PH_REST) begin
                     rest_count_in = count_inc;
                     for (int i = 0; i < 2; i++) begin
                        rest_sum_in[i] = rest_sum_ff[i] + REST_SUM_W'(samp_ff[i]);
                     end
                     if (count_inc > COUNT_W'(limit_ff)) begin
                        kind_in  = KIND_BIAS;
                        state_in = S_DIV_GO;
                     end
                  end else if (phase_ff == PH_REV) begin
                     dt_in        = pending_ff ? TS_W'(first_ff) : ts_ff - last_time_ff;
                     pending_in   = 1'b0;
                     last_time_in = ts_ff;
                     state_in     = S_MUL;
                  end
               end
               OP_START: begin
                  if (phase_ff != PH_REST) begin
                     phase_in    = PH_REV;
                     integ_in[0] = '0;
                     integ_in[1] = '0;
                     pending_in  = 1'b1;
                  end
               end
               OP_END: begin
                  if (phase_ff == PH_REV) begin
                     kind_in  = KIND_GAIN;
                     state_in = S_DIV_GO;
                  end
               end
               default: begin
                  kind_in  = KIND_MEAN;
                  state_in = S_DIV_GO;
               end
            endcase
         end
         S_MUL: begin
            prod_in  = term * $signed({1'b0, dt_ff});
            state_in = S_ACC;
         end
         S_ACC: begin
            integ_in[ch_ff] = sat_val;
            if (ch_ff) begin
               state_in = S_IDLE;
            end else begin
               ch_in    = 1'b1;
               state_in = S_MUL;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp_i.done) begin
               case (kind_ff)
                  KIND_BIAS: begin
                     bias_in[ch_ff]    = div_rsp_i.quot[BIAS_W-1:0];
                     res_val_in[ch_ff] = VALUE_W'(div_rsp_i.quot[BIAS_W-1:0]);
                     res_ok_in[ch_ff]  = 1'b1;
                  end
                  KIND_GAIN: begin
                     if (mag == '0) begin
                        res_val_in[ch_ff] = '0;
                        res_ok_in[ch_ff]  = 1'b0;
                     end else begin
                        res_val_in[ch_ff] = integ_cur[INTEG_W-1] ? (~gain_pos + 1'b1) : gain_pos;
                        res_ok_in[ch_ff]  = 1'b1;
                        if (gcount_ff[ch_ff] < MAX_COUNT) begin
                           gsum_in[ch_ff]   = gsum_add[GSUM_W] ? GSUM_MAX : gsum_add[GSUM_W-1:0];
                           gcount_in[ch_ff] = gcount_ff[ch_ff] + 1'b1;
                        end
                     end
                  end
                  default: begin
                     res_ok_in[ch_ff]  = (gcount_ff[ch_ff] != '0);
                     res_val_in[ch_ff] = (gcount_ff[ch_ff] != '0) ? div_rsp_i.quot : '0;
                  end
               endcase
               if (ch_ff) begin
                  state_in = S_EMIT;
                  if (kind_ff != KIND_MEAN) begin
                     phase_in = PH_IDLE;
                  end
               end else begin
                  ch_in    = 1'b1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_EMIT: begin
            if (slot_free_i) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_REST;
         limit_ff      <= LIMIT_RESET;
         first_ff      <= FIRST_RESET;
         rest_count_ff <= '0;
         rest_sum_ff   <= '{default: '0};
         bias_ff       <= '{default: '0};
         last_time_ff  <= '0;
         pending_ff    <= 1'b1;
         integ_ff      <= '{default: '0};
         gsum_ff       <= '{default: '0};
         gcount_ff     <= '{default: '0};
         ch_ff         <= 1'b0;
         kind_ff       <= KIND_BIAS;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         limit_ff      <= limit_in;
         first_ff      <= first_in;
         rest_count_ff <= rest_count_in;
         rest_sum_ff   <= rest_sum_in;
         bias_ff       <= bias_in;
         last_time_ff  <= last_time_in;
         pending_ff    <= pending_in;
         integ_ff      <= integ_in;
         gsum_ff       <= gsum_in;
         gcount_ff     <= gcount_in;
         ch_ff         <= ch_in;
         kind_ff       <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      samp_ff    <= samp_in;
      ts_ff      <= ts_in;
      dt_ff      <= dt_in;
      prod_ff    <= prod_in;
      res_val_ff <= res_val_in;
      res_ok_ff  <= res_ok_in;
   end

   assign div_req_o.start = div_start;
   assign div_req_o.num   = div_num;
   assign div_req_o.den   = div_den;

   assign result_o.valid    = (state_ff == S_EMIT) && slot_free_i;
   assign result_o.kind     = kind_ff;
   assign result_o.value_1x = res_val_ff[0];
   assign result_o.value_4x = res_val_ff[1];
   assign result_o.valid_1x = res_ok_ff[0];
   assign result_o.valid_4x = res_ok_ff[1];

   a_rest_count_bound: assert property (@(posedge clock) disable iff (reset)
      rest_count_ff <= COUNT_CEIL)
      else $error("rest sample count beyond its ceiling");

   a_gain_count_bound: assert property (@(posedge clock) disable iff (reset)
      (gcount_ff[0] <= MAX_COUNT) && (gcount_ff[1] <= MAX_COUNT))
      else $error("gain count beyond the revolution limit");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_req_o.start |-> !div_rsp_i.busy)
      else $error("division issued while the divider is busy");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid) |=> (state_ff == S_DISPATCH))
      else $error("accepted request not dispatched");

endmodule

@@ rtl/core/gyro_bias_and_gain_calibrator_unit.sv @@
// Gyro bias and gain calibrator, top level: sequencer, shared divider and
// the response register. Depends on gbgc_pkg, gbgc_seq and gbgc_div.
//
//   channel  direction  payload
//   req_     in         tuser: operation; tdata: sample_1x, sample_4x, timestamp_us
//   rsp_     out        tuser: result_kind; tdata: value_1x, value_4x, valid_1x, valid_4x
//   csr_     in         csr_index selects the register, csr_wdata the value
//
// A request that only updates state goes back to idle after dispatch; a
// sample inside a revolution uses one shared multiplier, two channels in turn,
// and a request that produces a result runs two 64-step divisions on the
// shared divider. Reset is synchronous; the response register parts the
// sides, so a new request is taken while a result waits on rsp_tready.
module gyro_bias_and_gain_calibrator_unit
   import gbgc_pkg::*;
#(
   parameter int ADC_BITS        = ADC_BITS_DEF,
   parameter int MAX_REVOLUTIONS = MAX_REV_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // sample_1x, sample_4x, timestamp_us
   input  logic [1:0]             req_tuser,   // operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // value_1x, value_4x, valid_1x, valid_4x
   output logic [KIND_W-1:0]      rsp_tuser    // result_kind
);

   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  result;
   logic        slot_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;

   gbgc_seq #(
      .ADC_BITS        (ADC_BITS),
      .MAX_REVOLUTIONS (MAX_REVOLUTIONS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .div_req_o   (div_req),
      .div_rsp_i   (div_rsp),
      .slot_free_i (slot_free),
      .result_o    (result)
   );

   gbgc_div u_div (
      .clock (clock),
      .reset (reset),
      .req_i (div_req),
      .rsp_o (div_rsp)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - 2*VALUE_W - 2){1'b0}},
                         result.valid_4x, result.valid_1x, result.value_4x, result.value_1x};
         rsp_kind_in  = result.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
